### rtl/smset_pkg.sv
// Shared constants, codes and types of the sorted marker set.
package smset_pkg;

  localparam int DEPTH     = 64;
  localparam int TIME_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int FUNC_BITS = 3;
  localparam int STAT_BITS = 2;
  localparam int DATA_W    = ((TIME_BITS + CNT_BITS + 7) / 8) * 8;
  localparam int PAD_BITS  = DATA_W - TIME_BITS - CNT_BITS;

  localparam logic [FUNC_BITS-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_EXACT  = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_PREV   = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_NEXT   = 3'd4;

  localparam logic [STAT_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_DUP  = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_FINISH
  } state_t;

endpackage

### rtl/smset_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_marker_set_top.sv
// Top level of the sorted marker set: control sequencer, marker RAM and output register.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | tdata: query_time; tuser: func
//   m_*      | out       | m_tvalid/m_tready  | tdata: result_time, marker_total; tuser: status
//   cfg_*    | in        | cfg_we             | cfg_wdata: clip_duration
//
// One word is worked on at a time. A word walks the marker RAM linearly, one entry
// per cycle through its single read port, until the first marker not below the query;
// an insert or delete then moves the tail of the list one entry per cycle, reading one
// address and writing the neighboring one. Reset empties the set at once through the
// marker count; the RAM needs no clearing. A stalled result waits in the output
// register while the next input word is already taken.
module sorted_marker_set_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [smset_pkg::TIME_BITS-1:0]       cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [smset_pkg::TIME_BITS-1:0]       s_tdata,   // [31:0] query_time
  input  logic [smset_pkg::FUNC_BITS-1:0]       s_tuser,   // [2:0] func
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [smset_pkg::DATA_W-1:0]          m_tdata,   // [31:0] result_time,
                                                           // [38:32] marker_total, [39] zero
  output logic [smset_pkg::STAT_BITS-1:0]       m_tuser    // [1:0] status
);

  localparam int TB = smset_pkg::TIME_BITS;
  localparam int IB = smset_pkg::IDX_BITS;
  localparam int CB = smset_pkg::CNT_BITS;
  localparam int SB = smset_pkg::STAT_BITS;

  // Control registers.
  smset_pkg::state_t state, state_next;
  logic [CB-1:0] count, count_next;
  logic [TB-1:0] clip, clip_next;
  logic          rd_valid, rd_valid_next;
  logic          issue_en, issue_en_next;
  logic          m_tvalid_next;

  // Payload registers.
  logic [smset_pkg::FUNC_BITS-1:0] func, func_next;
  logic [TB-1:0] qtime, qtime_next;
  logic [CB-1:0] idx, idx_next;
  logic [IB-1:0] rd_idx, rd_idx_next;
  logic [CB-1:0] pos, pos_next;
  logic [TB-1:0] prev_val, prev_val_next;
  logic          have_prev, have_prev_next;
  logic [TB-1:0] cur_val, cur_val_next;
  logic          found, found_next;
  logic          present, present_next;
  logic [TB-1:0] res_time, res_time_next;
  logic [SB-1:0] res_status, res_status_next;
  logic [CB-1:0] res_count, res_count_next;
  logic [smset_pkg::DATA_W-1:0] m_tdata_next;
  logic [SB-1:0] m_tuser_next;

  // RAM port.
  logic          ram_we;
  logic [IB-1:0] ram_waddr;
  logic [TB-1:0] ram_wdata;
  logic [IB-1:0] ram_raddr;
  logic [TB-1:0] rdata;

  smset_ram #(
    .WIDTH (TB),
    .DEPTH (smset_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  logic accept;
  logic scan_issue;
  logic hit;
  logic out_free;
  logic ins_ok;
  logic del_ok;
  logic ins_at_end;
  logic del_at_end;

  assign s_tready   = (state == smset_pkg::ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign scan_issue = (idx < count);
  // The first returned marker that is not below the query ends the walk.
  assign hit        = rd_valid && (rdata >= qtime);
  assign out_free   = !m_tvalid || m_tready;
  assign ins_ok     = (func == smset_pkg::FN_INSERT) && !present &&
                      (count != CB'(smset_pkg::DEPTH));
  assign del_ok     = (func == smset_pkg::FN_DELETE) && present;
  assign ins_at_end = (pos == count);
  assign del_at_end = ((pos + CB'(1)) == count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      smset_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = smset_pkg::ST_SCAN;
        end
      end
      smset_pkg::ST_SCAN: begin
        if (hit || (!rd_valid && !scan_issue)) begin
          state_next = smset_pkg::ST_DECIDE;
        end
      end
      smset_pkg::ST_DECIDE: begin
        if (ins_ok) begin
          state_next = ins_at_end ? smset_pkg::ST_PUT : smset_pkg::ST_SHIFT_UP;
        end else if (del_ok && !del_at_end) begin
          state_next = smset_pkg::ST_SHIFT_DN;
        end else begin
          state_next = smset_pkg::ST_FINISH;
        end
      end
      smset_pkg::ST_SHIFT_UP: begin
        if (!issue_en && !rd_valid) begin
          state_next = smset_pkg::ST_PUT;
        end
      end
      smset_pkg::ST_PUT: begin
        state_next = smset_pkg::ST_FINISH;
      end
      smset_pkg::ST_SHIFT_DN: begin
        if (!issue_en && !rd_valid) begin
          state_next = smset_pkg::ST_FINISH;
        end
      end
      smset_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = smset_pkg::ST_IDLE;
        end
      end
      default: state_next = smset_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_next      = count;
    clip_next       = cfg_we ? cfg_wdata : clip;
    rd_valid_next   = 1'b0;
    issue_en_next   = issue_en;
    m_tvalid_next   = m_tvalid && !m_tready;
    func_next       = func;
    qtime_next      = qtime;
    idx_next        = idx;
    rd_idx_next     = rd_idx;
    pos_next        = pos;
    prev_val_next   = prev_val;
    have_prev_next  = have_prev;
    cur_val_next    = cur_val;
    found_next      = found;
    present_next    = present;
    res_time_next   = res_time;
    res_status_next = res_status;
    res_count_next  = res_count;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    ram_we          = 1'b0;
    ram_waddr       = rd_idx;
    ram_wdata       = rdata;
    ram_raddr       = idx[IB-1:0];

    unique case (state)
      smset_pkg::ST_IDLE: begin
        if (accept) begin
          func_next      = s_tuser;
          qtime_next     = s_tdata;
          idx_next       = '0;
          have_prev_next = 1'b0;
          found_next     = 1'b0;
          present_next   = 1'b0;
        end
      end
      smset_pkg::ST_SCAN: begin
        // Reads stay one address ahead, so on a hit the read in flight is pos + 1.
        rd_valid_next = scan_issue;
        rd_idx_next   = idx[IB-1:0];
        if (scan_issue) begin
          idx_next = idx + CB'(1);
        end
        if (hit) begin
          found_next   = 1'b1;
          pos_next     = CB'(rd_idx);
          present_next = (rdata == qtime);
          cur_val_next = rdata;
        end else if (rd_valid) begin
          prev_val_next  = rdata;
          have_prev_next = 1'b1;
        end else if (!scan_issue) begin
          pos_next = count;
        end
      end
      smset_pkg::ST_DECIDE: begin
        res_time_next   = qtime;
        res_status_next = smset_pkg::STAT_OK;
        res_count_next  = count;
        case (func)
          smset_pkg::FN_INSERT: begin
            if (present) begin
              res_status_next = smset_pkg::STAT_DUP;
            end else if (count == CB'(smset_pkg::DEPTH)) begin
              res_status_next = smset_pkg::STAT_FULL;
            end else begin
              res_count_next = count + CB'(1);
              idx_next       = count - CB'(1);
              issue_en_next  = !ins_at_end;
            end
          end
          smset_pkg::FN_DELETE: begin
            if (present) begin
              res_count_next = count - CB'(1);
              idx_next       = pos + CB'(1);
              issue_en_next  = !del_at_end;
            end else begin
              res_status_next = smset_pkg::STAT_NONE;
            end
          end
          smset_pkg::FN_EXACT: begin
            if (!present) begin
              res_time_next   = '0;
              res_status_next = smset_pkg::STAT_NONE;
            end
          end
          smset_pkg::FN_PREV: begin
            if (have_prev) begin
              res_time_next = prev_val;
            end else begin
              res_time_next   = '0;
              res_status_next = smset_pkg::STAT_NONE;
            end
          end
          smset_pkg::FN_NEXT: begin
            // On an exact match the successor is the word read just behind the hit.
            if (present ? rd_valid : found) begin
              res_time_next = present ? rdata : cur_val;
            end else begin
              res_time_next   = clip;
              res_status_next = smset_pkg::STAT_NONE;
            end
          end
          default: begin
            res_status_next = smset_pkg::STAT_NONE;
          end
        endcase
      end
      smset_pkg::ST_SHIFT_UP: begin
        // Walk down from the last entry; each word lands one address higher.
        if (issue_en) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = idx[IB-1:0];
          if (idx == pos) begin
            issue_en_next = 1'b0;
          end else begin
            idx_next = idx - CB'(1);
          end
        end
        if (rd_valid) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx + IB'(1);
          ram_wdata = rdata;
        end
      end
      smset_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos[IB-1:0];
        ram_wdata = qtime;
      end
      smset_pkg::ST_SHIFT_DN: begin
        // Walk up from the entry after the match; each word lands one address lower.
        if (issue_en) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = idx[IB-1:0];
          if (idx == (count - CB'(1))) begin
            issue_en_next = 1'b0;
          end else begin
            idx_next = idx + CB'(1);
          end
        end
        if (rd_valid) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx - IB'(1);
          ram_wdata = rdata;
        end
      end
      smset_pkg::ST_FINISH: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {{smset_pkg::PAD_BITS{1'b0}}, res_count, res_time};
          m_tuser_next  = res_status;
          count_next    = res_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= smset_pkg::ST_IDLE;
      count    <= '0;
      clip     <= '0;
      rd_valid <= 1'b0;
      issue_en <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      clip     <= clip_next;
      rd_valid <= rd_valid_next;
      issue_en <= issue_en_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    func       <= func_next;
    qtime      <= qtime_next;
    idx        <= idx_next;
    rd_idx     <= rd_idx_next;
    pos        <= pos_next;
    prev_val   <= prev_val_next;
    have_prev  <= have_prev_next;
    cur_val    <= cur_val_next;
    found      <= found_next;
    present    <= present_next;
    res_time   <= res_time_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

endmodule

### rtl/smset_checker.sv
// Port-level checker for the sorted marker set, bound to the top level.
module smset_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [smset_pkg::DATA_W-1:0]     m_tdata,
  input logic [smset_pkg::STAT_BITS-1:0]  m_tuser
);

  localparam int TB = smset_pkg::TIME_BITS;
  localparam int CB = smset_pkg::CNT_BITS;

  // Only one word is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again while a word is in work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // The marker total never exceeds the store.
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[TB+CB-1:TB] <= CB'(smset_pkg::DEPTH)))
    else $error("marker total beyond depth");

  // Full is only reported when the store really holds DEPTH markers.
  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == smset_pkg::STAT_FULL)) |->
      (m_tdata[TB+CB-1:TB] == CB'(smset_pkg::DEPTH)))
    else $error("full reported on a store that is not full");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_marker_set_top smset_checker u_smset_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### sim/sorted_marker_set_top_tb.sv
// Self-checking testbench for the sorted marker set: empty set, directed edits, full store, stalls, random mix.
module sorted_marker_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB    = smset_pkg::TIME_BITS;
  localparam int FB    = smset_pkg::FUNC_BITS;
  localparam int SB    = smset_pkg::STAT_BITS;
  localparam int CB    = smset_pkg::CNT_BITS;
  localparam int DW    = smset_pkg::DATA_W;
  localparam int DEPTH = smset_pkg::DEPTH;

  // Cycles without any accepted word before the run is declared hung. The slowest
  // legal gap is the long receiver hold below plus one full-length edit.
  localparam int QUIET_LIMIT   = 5000;
  localparam int RX_HOLD_LEN   = 300;
  localparam int IDLE_PCT      = 15;
  localparam int TAIL_CYCLES   = 100;

  // One expected result word, with its fields split out.
  typedef struct packed {
    logic [TB-1:0] result_time;
    logic [SB-1:0] status;
    logic [CB-1:0] marker_total;
  } marker_reply_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [TB-1:0]          cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TB-1:0]          s_tdata   = '0;
  logic [FB-1:0]          s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [DW-1:0]          m_tdata;
  logic [SB-1:0]          m_tuser;

  // Shadow copy of the block's state: the sorted markers and the clip length.
  logic [TB-1:0]          marker_list[$];
  logic [TB-1:0]          clip_shadow;
  marker_reply_t          pending_replies[$];

  int                     error_count = 0;
  int                     quiet_cycles = 0;
  bit                     idle_on = 1'b1;
  bit                     rx_hold_req = 1'b0;
  int                     rx_hold_left = 0;

  sorted_marker_set_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the reply to one operation and applies any edit to the shadow set.
  // The search finds the first marker not below the query, as the block does.
  function automatic marker_reply_t predict_marker_op(input logic [FB-1:0] op,
                                                      input logic [TB-1:0] t);
    marker_reply_t r;
    int            pos;
    bit            present;
    pos = 0;
    while (pos < marker_list.size() && marker_list[pos] < t) pos++;
    present = (pos < marker_list.size()) && (marker_list[pos] == t);
    r.result_time = t;
    r.status      = smset_pkg::STAT_OK;
    case (op)
      smset_pkg::FN_INSERT: begin
        if (present) r.status = smset_pkg::STAT_DUP;
        else if (marker_list.size() >= DEPTH) r.status = smset_pkg::STAT_FULL;
        else marker_list.insert(pos, t);
      end
      smset_pkg::FN_DELETE: begin
        if (present) marker_list.delete(pos);
        else r.status = smset_pkg::STAT_NONE;
      end
      smset_pkg::FN_EXACT: begin
        if (!present) begin
          r.result_time = '0;
          r.status      = smset_pkg::STAT_NONE;
        end
      end
      smset_pkg::FN_PREV: begin
        if (pos > 0) begin
          r.result_time = marker_list[pos-1];
        end else begin
          r.result_time = '0;
          r.status      = smset_pkg::STAT_NONE;
        end
      end
      smset_pkg::FN_NEXT: begin
        // An exact hit is skipped: next means strictly above the query.
        if (present) pos++;
        if (pos < marker_list.size()) begin
          r.result_time = marker_list[pos];
        end else begin
          r.result_time = clip_shadow;
          r.status      = smset_pkg::STAT_NONE;
        end
      end
      default: r.status = smset_pkg::STAT_NONE;
    endcase
    r.marker_total = CB'(marker_list.size());
    return r;
  endfunction

  // Picks a query time. Mode 0 is uniform, 1 lands on or next to a held marker,
  // 2 keeps to a narrow range so that duplicates and a full store come often,
  // and 3 picks one of the extremes of the field.
  function automatic logic [TB-1:0] pick_time(input int mode);
    logic [TB-1:0] v;
    v = $urandom;
    case (mode)
      1: begin
        if (marker_list.size() > 0) begin
          v = marker_list[$urandom_range(marker_list.size() - 1)];
          v = v + TB'($urandom_range(2)) - TB'(1);
        end
      end
      2: v = TB'($urandom_range(255));
      3: begin
        case ($urandom_range(3))
          0:       v = '0;
          1:       v = TB'(1);
          2:       v = '1 - TB'(1);
          default: v = '1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offers one word, with a random gap in front of it, and records the reply it
  // must cause once the block takes it. Valid stays high after acceptance so
  // that back-to-back words need no extra edge.
  task automatic send_word(input logic [FB-1:0] op, input logic [TB-1:0] t);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_replies.push_back(predict_marker_op(op, t));
  endtask

  // The sender goes quiet until every reply it is owed has come back.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
  endtask

  // Every word causes exactly one reply, so the block is idle once drained.
  task automatic write_clip(input logic [TB-1:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clip_shadow = value;
  endtask

  // Queries on an empty set, a delete that misses, and the unused operation
  // codes, all with the clip length still at its reset value of zero.
  task automatic test_empty_set();
    send_word(smset_pkg::FN_EXACT, '0);
    send_word(smset_pkg::FN_PREV, '1);
    send_word(smset_pkg::FN_NEXT, '0);
    send_word(smset_pkg::FN_NEXT, '1);
    send_word(smset_pkg::FN_DELETE, TB'(5));
    for (int c = smset_pkg::FN_NEXT + 1; c < (1 << FB); c++)
      send_word(FB'(c), $urandom);
  endtask

  // Hand-picked edits at both ends of the time range, a duplicate, misses and
  // hits for every query, and deletes down to an empty set again.
  task automatic test_directed_edits();
    write_clip('1);
    send_word(smset_pkg::FN_INSERT, '0);
    send_word(smset_pkg::FN_INSERT, '1);
    send_word(smset_pkg::FN_INSERT, TB'(1000));
    send_word(smset_pkg::FN_INSERT, TB'(1000));
    send_word(smset_pkg::FN_EXACT, TB'(1000));
    send_word(smset_pkg::FN_EXACT, TB'(999));
    send_word(smset_pkg::FN_PREV, '0);
    send_word(smset_pkg::FN_PREV, TB'(1000));
    send_word(smset_pkg::FN_PREV, '1);
    send_word(smset_pkg::FN_NEXT, '0);
    send_word(smset_pkg::FN_NEXT, TB'(1000));
    send_word(smset_pkg::FN_NEXT, '1);
    send_word(smset_pkg::FN_DELETE, TB'(1000));
    send_word(smset_pkg::FN_DELETE, TB'(1000));
    send_word(smset_pkg::FN_DELETE, '0);
    send_word(smset_pkg::FN_DELETE, '1);
  endtask

  // Fills the store, then hits it with a new time (full) and a held time
  // (duplicate wins over full), frees one slot and fills it again.
  task automatic test_full_store();
    logic [TB-1:0] fresh;
    int            hits[$];
    write_clip($urandom);
    while (marker_list.size() < DEPTH) send_word(smset_pkg::FN_INSERT, $urandom);
    do begin
      fresh = $urandom;
      hits  = marker_list.find_first_index(x) with (x == fresh);
    end while (hits.size() > 0);
    send_word(smset_pkg::FN_INSERT, fresh);
    send_word(smset_pkg::FN_INSERT, marker_list[$urandom_range(DEPTH - 1)]);
    send_word(smset_pkg::FN_NEXT, marker_list[DEPTH-1]);
    send_word(smset_pkg::FN_PREV, marker_list[0]);
    send_word(smset_pkg::FN_EXACT, marker_list[DEPTH-1]);
    send_word(smset_pkg::FN_DELETE, marker_list[0]);
    send_word(smset_pkg::FN_INSERT, fresh);
    send_word(smset_pkg::FN_INSERT, fresh + TB'(1));
  endtask

  // A run of random words. The split between inserts and deletes steers the
  // fill level; the rest are queries and a few unused codes.
  task automatic random_phase(input int n_words, input int insert_pct, input int delete_pct);
    logic [FB-1:0] op;
    int            roll;
    int            mode;
    for (int n = 0; n < n_words; n++) begin
      roll = $urandom_range(99);
      mode = $urandom_range(3);
      if (roll < insert_pct) begin
        op = smset_pkg::FN_INSERT;
      end else if (roll < insert_pct + delete_pct) begin
        op = smset_pkg::FN_DELETE;
        if ($urandom_range(99) < 60) mode = 1;
      end else if (roll < 97) begin
        op = FB'(smset_pkg::FN_EXACT + $urandom_range(2));
      end else begin
        op = FB'($urandom_range(smset_pkg::FN_NEXT + 1, (1 << FB) - 1));
      end
      send_word(op, pick_time(mode));
    end
  endtask

  // The receiver refuses results for a long stretch while words keep coming,
  // so the output register fills and the block has to stall its input.
  task automatic test_output_stall();
    wait_drain();
    rx_hold_req <= 1'b1;
    random_phase(40, 40, 20);
  endtask

  // Random edits and queries over several clip lengths, extremes included. One
  // phase runs with no idling on either side.
  task automatic test_random_mix();
    write_clip('0);
    random_phase(180, 60, 10);
    write_clip('1);
    random_phase(180, 35, 35);
    write_clip($urandom);
    idle_on = 1'b0;
    random_phase(180, 30, 30);
    idle_on = 1'b1;
    write_clip($urandom);
    random_phase(180, 10, 60);
    write_clip(TB'(1));
    random_phase(180, 55, 15);
    write_clip($urandom);
    random_phase(180, 20, 50);
  endtask

  // Receiver: random idling, plus the long hold that a test can ask for.
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req  <= 1'b0;
      rx_hold_left <= RX_HOLD_LEN;
      m_tready     <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Each accepted result word is compared with the oldest expected reply.
  always @(posedge clk) begin
    marker_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with none expected: time %h status %0d total %0d",
                 $time, m_tdata[TB-1:0], m_tuser, m_tdata[TB +: CB]);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[TB-1:0] !== want.result_time) begin
          $display("%0t: result_time expected %h actual %h",
                   $time, want.result_time, m_tdata[TB-1:0]);
          error_count++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[TB +: CB] !== want.marker_total) begin
          $display("%0t: marker_total expected %0d actual %0d",
                   $time, want.marker_total, m_tdata[TB +: CB]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clip_shadow = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_set();
    test_directed_edits();
    test_full_store();
    test_output_stall();
    test_random_mix();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() > 0) begin
      $display("%0t: %0d expected result words never arrived", $time, pending_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
